FILE: hdl/assert_macros.svh
// Assertion helpers shared by the RTL.
// Build with NO_ASSERTIONS defined to drop every check.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property must hold at every clock edge out of reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// Expression must never be true out of reset.
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");

`else

`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)

`endif

`endif

FILE: hdl/tas_pkg.sv
`default_nettype none

package tas_pkg;

    // table geometry
    localparam int MAX_FACES   = 1024;
    localparam int VERTEX_BITS = 16;
    localparam int SLOT_W      = $clog2(MAX_FACES);
    localparam int CNT_W       = $clog2(MAX_FACES + 1);
    localparam int FACE_W      = 3 * VERTEX_BITS;

    // fixed port widths
    localparam int VERT_W      = 16;
    localparam int FACE_SLOT_W = 10;
    localparam int CFG_W       = 11;

    // command codes
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef enum logic {
        S_IDLE,
        S_SCAN
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load;     // write the input word into the face table
        logic start;    // capture query, rewind scan
        logic advance;  // issue next table read
        logic finish;   // move result into the output register
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic hit;        // face in the read register matches
        logic exhausted;  // all faces read, nothing in flight
        logic out_free;   // output register can take a word now
    } t_dp_stat;

endpackage

`default_nettype wire

FILE: hdl/triangle_adjacency_search.sv
`default_nettype none

// Triangle adjacency search.
// Input channel (i_in_valid / o_in_stall) carries one word per command:
//   load  (i_command = 0) writes corners a, b, c into slot i_face_slot;
//         taken while idle, gives no output word.
//   query (i_command = 1) searches faces 0 .. min(face_count, 1024)-1 for edge (a,b)
//         in either direction whose opposite corner differs from c.
// Output channel (o_out_valid / i_out_stall) gives one word per query:
//   the neighbour's opposite corner with o_found = 1, or c with o_found = 0.
// Query scan: one face read per cycle from the face table while the scan
// runs. A hit ends the scan at the matching face, a miss once all
// min(face_count, 1024) faces are read, an empty table without a read. The input is
// stalled for the whole scan and free again from the edge that loads the
// output word, so queries run one at a time. A load or query may be
// accepted while an earlier result still waits. If the receiver stalls, a
// finished scan holds until the output register frees; the face table
// itself keeps its contents. Reset clears face_count to zero and empties
// the output register; table slots are undefined until loaded. i_cfg_we
// writes face_count; the user must use it only when idle (not enforced).

module triangle_adjacency_search
    import tas_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_we,
    input  wire logic [CFG_W-1:0]       i_cfg_wdata,
    input  wire logic                   i_in_valid,
    output logic                        o_in_stall,
    input  wire logic                   i_command,
    input  wire logic [FACE_SLOT_W-1:0] i_face_slot,
    input  wire logic [VERT_W-1:0]      i_vert_a,
    input  wire logic [VERT_W-1:0]      i_vert_b,
    input  wire logic [VERT_W-1:0]      i_vert_c,
    output logic                        o_out_valid,
    input  wire logic                   i_out_stall,
    output logic [VERT_W-1:0]           o_adjacent_vertex,
    output logic                        o_found
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    // sequencer: idle / scan
    tas_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_command  (i_command),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd),
        .o_in_stall (o_in_stall)
    );

    // face table, scan counter, edge compare, output register
    tas_datapath u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_face_slot       (i_face_slot),
        .i_vert_a          (i_vert_a),
        .i_vert_b          (i_vert_b),
        .i_vert_c          (i_vert_c),
        .i_out_stall       (i_out_stall),
        .i_cmd             (w_cmd),
        .o_stat            (w_stat),
        .o_out_valid       (o_out_valid),
        .o_adjacent_vertex (o_adjacent_vertex),
        .o_found           (o_found)
    );

endmodule

`default_nettype wire

FILE: hdl/tas_ctrl.sv
`default_nettype none

`include "assert_macros.svh"

module tas_ctrl
    import tas_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    input  wire logic     i_command,
    input  wire t_dp_stat i_stat,
    output t_dp_cmd       o_cmd,
    output logic          o_in_stall
);

    t_state r_state;
    t_state n_state;
    logic   w_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign w_done = i_stat.hit || i_stat.exhausted;

    always_comb begin
        n_state       = r_state;
        o_cmd.load    = 1'b0;
        o_cmd.start   = 1'b0;
        o_cmd.advance = 1'b0;
        o_cmd.finish  = 1'b0;
        o_in_stall    = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    if (i_command == CMD_QUERY) begin
                        o_cmd.start = 1'b1;
                        n_state     = S_SCAN;
                    end else begin
                        o_cmd.load = 1'b1;
                    end
                end
            end
            S_SCAN: begin
                if (w_done) begin
                    // hold the scan until the output register frees up
                    if (i_stat.out_free) begin
                        o_cmd.finish = 1'b1;
                        n_state      = S_IDLE;
                    end
                end else begin
                    o_cmd.advance = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    `ASSERT_NEVER(a_adv_fin_excl, i_clk, i_rst_n, o_cmd.advance && o_cmd.finish)
    `ASSERT_PROP(a_start_to_scan, i_clk, i_rst_n, o_cmd.start |=> r_state == S_SCAN)
    `ASSERT_PROP(a_blocked_holds, i_clk, i_rst_n,
        (r_state == S_SCAN && w_done && !i_stat.out_free) |=> r_state == S_SCAN)

endmodule

`default_nettype wire

FILE: hdl/tas_datapath.sv
`default_nettype none

`include "assert_macros.svh"

module tas_datapath
    import tas_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_we,
    input  wire logic [CFG_W-1:0]       i_cfg_wdata,
    input  wire logic [FACE_SLOT_W-1:0] i_face_slot,
    input  wire logic [VERT_W-1:0]      i_vert_a,
    input  wire logic [VERT_W-1:0]      i_vert_b,
    input  wire logic [VERT_W-1:0]      i_vert_c,
    input  wire logic                   i_out_stall,
    input  wire t_dp_cmd                i_cmd,
    output t_dp_stat                    o_stat,
    output logic                        o_out_valid,
    output logic [VERT_W-1:0]           o_adjacent_vertex,
    output logic                        o_found
);

    logic [FACE_W-1:0]      r_mem [MAX_FACES];
    logic [CFG_W-1:0]       r_face_count;
    logic [CNT_W-1:0]       r_limit;
    logic [CNT_W-1:0]       r_addr;
    logic [FACE_W-1:0]      r_rd_data;
    logic                   r_rd_vld;
    logic [VERTEX_BITS-1:0] r_ea;
    logic [VERTEX_BITS-1:0] r_eb;
    logic [VERTEX_BITS-1:0] r_excl;
    logic                   r_out_valid;
    logic [VERT_W-1:0]      r_out_vertex;
    logic                   r_out_found;

    logic [VERTEX_BITS-1:0] w_c0;
    logic [VERTEX_BITS-1:0] w_c1;
    logic [VERTEX_BITS-1:0] w_c2;
    logic                   w_m0;
    logic                   w_m1;
    logic                   w_m2;
    logic [VERTEX_BITS-1:0] w_opp;
    logic                   w_slot_ok;
    logic                   w_more;
    logic [CNT_W-1:0]       w_limit;

    // register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_face_count <= '0;
        end else if (i_cfg_we) begin
            r_face_count <= i_cfg_wdata;
        end
    end

    assign w_limit = (32'(r_face_count) > 32'(MAX_FACES)) ? CNT_W'(MAX_FACES)
                                                           : CNT_W'(r_face_count);

    // face table: one write port, one registered read port
    assign w_slot_ok = (32'(i_face_slot) < 32'(MAX_FACES));

    always_ff @(posedge i_clk) begin
        if (i_cmd.load && w_slot_ok) begin
            r_mem[SLOT_W'(i_face_slot)] <= {VERTEX_BITS'(i_vert_c),
                                            VERTEX_BITS'(i_vert_b),
                                            VERTEX_BITS'(i_vert_a)};
        end
    end

    assign w_more = (r_addr < r_limit);

    always_ff @(posedge i_clk) begin
        if (i_cmd.advance && w_more) begin
            r_rd_data <= r_mem[r_addr[SLOT_W-1:0]];
        end
    end

    // scan control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
            r_addr   <= '0;
            r_limit  <= '0;
        end else if (i_cmd.start) begin
            r_rd_vld <= 1'b0;
            r_addr   <= '0;
            r_limit  <= w_limit;
        end else if (i_cmd.advance) begin
            r_rd_vld <= w_more;
            if (w_more) begin
                r_addr <= r_addr + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_ea   <= VERTEX_BITS'(i_vert_a);
            r_eb   <= VERTEX_BITS'(i_vert_b);
            r_excl <= VERTEX_BITS'(i_vert_c);
        end
    end

    // edge compare, edges (c0,c1) (c1,c2) (c2,c0) in priority order
    assign w_c0 = r_rd_data[VERTEX_BITS-1:0];
    assign w_c1 = r_rd_data[2*VERTEX_BITS-1:VERTEX_BITS];
    assign w_c2 = r_rd_data[3*VERTEX_BITS-1:2*VERTEX_BITS];

    assign w_m0 = ((w_c0 == r_ea && w_c1 == r_eb) || (w_c1 == r_ea && w_c0 == r_eb))
                  && (w_c2 != r_excl);
    assign w_m1 = ((w_c1 == r_ea && w_c2 == r_eb) || (w_c2 == r_ea && w_c1 == r_eb))
                  && (w_c0 != r_excl);
    assign w_m2 = ((w_c2 == r_ea && w_c0 == r_eb) || (w_c0 == r_ea && w_c2 == r_eb))
                  && (w_c1 != r_excl);

    assign w_opp = w_m0 ? w_c2 : (w_m1 ? w_c0 : w_c1);

    assign o_stat.hit       = r_rd_vld && (w_m0 || w_m1 || w_m2);
    assign o_stat.exhausted = !r_rd_vld && !w_more;
    assign o_stat.out_free  = !r_out_valid || !i_out_stall;

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out_vertex <= o_stat.hit ? VERT_W'(w_opp) : VERT_W'(r_excl);
            r_out_found  <= o_stat.hit;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_adjacent_vertex = r_out_vertex;
    assign o_found           = r_out_found;

    `ASSERT_PROP(a_addr_in_range, i_clk, i_rst_n, r_addr <= r_limit)
    `ASSERT_PROP(a_finish_loads_out, i_clk, i_rst_n, i_cmd.finish |=> r_out_valid)
    `ASSERT_PROP(a_finish_when_done, i_clk, i_rst_n,
        i_cmd.finish |-> (o_stat.hit || o_stat.exhausted) && o_stat.out_free)

endmodule

`default_nettype wire
